/* sv/rcspt_pkg.sv */
// Shared widths, codes and types of the reference-counted shared page table.
package rcspt_pkg;

    localparam int ENTRIES_DEF = 64;

    localparam int OP_W     = 2;
    localparam int FILE_W   = 16;
    localparam int OFFSET_W = 40;
    localparam int IDX_W    = 6;
    localparam int FRAME_W  = 20;
    localparam int STS_W    = 3;
    localparam int FLT_W    = 2;
    localparam int CNT_W    = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd0;
    localparam logic [OP_W-1:0] OP_CREATE  = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    localparam logic [STS_W-1:0] STS_HIT       = 3'd0;
    localparam logic [STS_W-1:0] STS_CREATED   = 3'd1;
    localparam logic [STS_W-1:0] STS_NOT_FOUND = 3'd2;
    localparam logic [STS_W-1:0] STS_FULL      = 3'd3;
    localparam logic [STS_W-1:0] STS_NO_FRAME  = 3'd4;
    localparam logic [STS_W-1:0] STS_REL_HELD  = 3'd5;
    localparam logic [STS_W-1:0] STS_REL_FREED = 3'd6;

    localparam logic [FLT_W-1:0] FLT_NONE     = 2'd0;
    localparam logic [FLT_W-1:0] FLT_NOT_HELD = 2'd1;
    localparam logic [FLT_W-1:0] FLT_AT_MAX   = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0]    count;
        logic [FILE_W-1:0]   file;
        logic [OFFSET_W-1:0] offset;
        logic [FRAME_W-1:0]  frame;
    } t_entry;

    typedef struct packed {
        logic live;
        logic match;
        logic at_max;
        logic last_ref;
    } t_cmp;

endpackage

/* sv/rcspt_if.sv */
// Request and response channel interfaces of the shared page table.
interface rcspt_req_if import rcspt_pkg::*;;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [FILE_W-1:0]   file_id;
    logic [OFFSET_W-1:0] file_offset;
    logic [IDX_W-1:0]    entry_index;
    logic [FRAME_W-1:0]  offered_frame;
    logic                frame_available;

    modport source (
        output valid, opcode, file_id, file_offset, entry_index, offered_frame,
               frame_available,
        input  ready
    );
    modport sink (
        input  valid, opcode, file_id, file_offset, entry_index, offered_frame,
               frame_available,
        output ready
    );
endinterface

interface rcspt_rsp_if import rcspt_pkg::*;;
    logic               valid;
    logic               ready;
    logic [STS_W-1:0]   status;
    logic [IDX_W-1:0]   result_index;
    logic [FRAME_W-1:0] result_frame;
    logic [FLT_W-1:0]   fault;

    modport source (
        output valid, status, result_index, result_frame, fault,
        input  ready
    );
    modport sink (
        input  valid, status, result_index, result_frame, fault,
        output ready
    );
endinterface

/* sv/rcspt_cmp.sv */
// Shared entry compare unit: liveness, key match and count limits of one entry.
module rcspt_cmp import rcspt_pkg::*; (
    input  t_entry              i_entry,
    input  logic [FILE_W-1:0]   i_file,
    input  logic [OFFSET_W-1:0] i_offset,
    output t_cmp                o_cmp
);

    always_comb begin
        o_cmp.live     = (i_entry.count != '0);
        o_cmp.match    = (i_entry.file == i_file) && (i_entry.offset == i_offset);
        o_cmp.at_max   = (i_entry.count == COUNT_MAX);
        o_cmp.last_ref = (i_entry.count == CNT_W'(1));
    end

endmodule

/* sv/refcounted_shared_page_table.sv */
// Top level of the reference-counted shared page table.
// Lookup / lookup-or-create: one sequential scan that stops at a hit; a miss, create, full
// or no-frame result is given once the last entry has been compared.
// Release: reads the indexed entry, then updates its count; an out-of-range index skips the read.
// Requests: one at a time; ready stays low from accept until the result is loaded for output.
// Reset: synchronous, active low; then a clearing pass over every entry with ready low.
module refcounted_shared_page_table import rcspt_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rcspt_req_if.sink    i_req,
    rcspt_rsp_if.source  o_rsp
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int XW = ((IW > IDX_W) ? IW : IDX_W) + 1;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
    localparam logic [XW-1:0] DEPTH = XW'(ENTRIES);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_REL   = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    t_entry r_mem [ENTRIES];

    logic [2:0]          r_state, n_state;
    logic [IW-1:0]       r_addr, n_addr;
    logic                r_issued, n_issued;
    logic                r_rd_vld, n_rd_vld;
    logic [IW-1:0]       r_rd_idx, n_rd_idx;
    logic                r_free_found, n_free_found;
    logic [IW-1:0]       r_free_idx, n_free_idx;
    logic                r_ov, n_ov;

    logic [OP_W-1:0]     r_op, n_op;
    logic [FILE_W-1:0]   r_fid, n_fid;
    logic [OFFSET_W-1:0] r_off, n_off;
    logic [IDX_W-1:0]    r_sel, n_sel;
    logic [FRAME_W-1:0]  r_frame, n_frame;
    logic                r_avail, n_avail;

    logic [STS_W-1:0]    r_sts, n_sts;
    logic [IDX_W-1:0]    r_ridx, n_ridx;
    logic [FRAME_W-1:0]  r_rframe, n_rframe;
    logic [FLT_W-1:0]    r_flt, n_flt;

    logic [STS_W-1:0]    r_o_sts, n_o_sts;
    logic [IDX_W-1:0]    r_o_idx, n_o_idx;
    logic [FRAME_W-1:0]  r_o_frame, n_o_frame;
    logic [FLT_W-1:0]    r_o_flt, n_o_flt;

    t_entry              r_rd_data;
    t_cmp                w_cmp;
    logic                w_we;
    logic [IW-1:0]       w_wa;
    logic [IW-1:0]       w_ra;
    t_entry              w_wd;
    logic                w_accept;
    logic [XW-1:0]       w_sel_ext;
    logic                w_sel_ok;
    logic                w_any_free;
    logic [IW-1:0]       w_fidx;

    rcspt_cmp u_cmp (
        .i_entry  (r_rd_data),
        .i_file   (r_fid),
        .i_offset (r_off),
        .o_cmp    (w_cmp)
    );

    assign i_req.ready        = (r_state == S_IDLE);
    assign w_accept           = i_req.valid && (r_state == S_IDLE);
    assign w_sel_ext          = XW'(i_req.entry_index);
    assign w_sel_ok           = (w_sel_ext < DEPTH);
    assign w_any_free         = r_free_found || !w_cmp.live;
    assign w_fidx             = r_free_found ? r_free_idx : r_rd_idx;

    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_o_sts;
    assign o_rsp.result_index = r_o_idx;
    assign o_rsp.result_frame = r_o_frame;
    assign o_rsp.fault        = r_o_flt;

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_issued     = r_issued;
        n_rd_vld     = r_rd_vld;
        n_rd_idx     = r_rd_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_op         = r_op;
        n_fid        = r_fid;
        n_off        = r_off;
        n_sel        = r_sel;
        n_frame      = r_frame;
        n_avail      = r_avail;
        n_sts        = r_sts;
        n_ridx       = r_ridx;
        n_rframe     = r_rframe;
        n_flt        = r_flt;
        n_ov         = r_ov && !o_rsp.ready;
        n_o_sts      = r_o_sts;
        n_o_idx      = r_o_idx;
        n_o_frame    = r_o_frame;
        n_o_flt      = r_o_flt;
        w_we         = 1'b0;
        w_wa         = r_addr;
        w_wd         = '0;
        w_ra         = r_addr;

        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                w_wa = r_addr;
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + IW'(1);
                end
            end
            S_IDLE: begin
                w_ra = w_sel_ext[IW-1:0];
                if (w_accept) begin
                    n_op     = i_req.opcode;
                    n_fid    = i_req.file_id;
                    n_off    = i_req.file_offset;
                    n_sel    = i_req.entry_index;
                    n_frame  = i_req.offered_frame;
                    n_avail  = i_req.frame_available;
                    n_rd_idx = w_sel_ext[IW-1:0];
                    if (i_req.opcode == OP_RELEASE) begin
                        if (w_sel_ok) begin
                            n_state = S_REL;
                        end else begin
                            n_sts    = STS_REL_HELD;
                            n_ridx   = i_req.entry_index;
                            n_rframe = '0;
                            n_flt    = FLT_NOT_HELD;
                            n_state  = S_RESP;
                        end
                    end else begin
                        n_addr       = '0;
                        n_issued     = 1'b0;
                        n_rd_vld     = 1'b0;
                        n_free_found = 1'b0;
                        n_state      = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                w_ra = r_addr;
                if (!r_issued) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_addr;
                    if (r_addr == LAST) begin
                        n_issued = 1'b1;
                    end else begin
                        n_addr = r_addr + IW'(1);
                    end
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (r_rd_vld) begin
                    if (w_cmp.live && w_cmp.match) begin
                        n_sts    = STS_HIT;
                        n_ridx   = IDX_W'(r_rd_idx);
                        n_rframe = r_rd_data.frame;
                        n_state  = S_RESP;
                        if (w_cmp.at_max) begin
                            n_flt = FLT_AT_MAX;
                        end else begin
                            n_flt      = FLT_NONE;
                            w_we       = 1'b1;
                            w_wa       = r_rd_idx;
                            w_wd       = r_rd_data;
                            w_wd.count = r_rd_data.count + CNT_W'(1);
                        end
                    end else begin
                        if (!w_cmp.live && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_rd_idx;
                        end
                        if (r_rd_idx == LAST) begin
                            n_state  = S_RESP;
                            n_ridx   = '0;
                            n_rframe = '0;
                            n_flt    = FLT_NONE;
                            if (r_op != OP_CREATE) begin
                                n_sts = STS_NOT_FOUND;
                            end else if (!w_any_free) begin
                                n_sts = STS_FULL;
                            end else if (!r_avail) begin
                                n_sts = STS_NO_FRAME;
                            end else begin
                                n_sts       = STS_CREATED;
                                n_ridx      = IDX_W'(w_fidx);
                                n_rframe    = r_frame;
                                w_we        = 1'b1;
                                w_wa        = w_fidx;
                                w_wd.count  = CNT_W'(1);
                                w_wd.file   = r_fid;
                                w_wd.offset = r_off;
                                w_wd.frame  = r_frame;
                            end
                        end
                    end
                end
            end
            S_REL: begin
                n_ridx  = r_sel;
                n_state = S_RESP;
                w_wa    = r_rd_idx;
                if (!w_cmp.live) begin
                    n_sts    = STS_REL_HELD;
                    n_rframe = '0;
                    n_flt    = FLT_NOT_HELD;
                end else if (w_cmp.last_ref) begin
                    n_sts    = STS_REL_FREED;
                    n_rframe = r_rd_data.frame;
                    n_flt    = FLT_NONE;
                    w_we     = 1'b1;
                end else begin
                    n_sts      = STS_REL_HELD;
                    n_rframe   = '0;
                    n_flt      = FLT_NONE;
                    w_we       = 1'b1;
                    w_wd       = r_rd_data;
                    w_wd.count = r_rd_data.count - CNT_W'(1);
                end
            end
            S_RESP: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov      = 1'b1;
                    n_o_sts   = r_sts;
                    n_o_idx   = r_ridx;
                    n_o_frame = r_rframe;
                    n_o_flt   = r_flt;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_issued     <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_free_found <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_issued     <= n_issued;
            r_rd_vld     <= n_rd_vld;
            r_free_found <= n_free_found;
            r_ov         <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_free_idx <= n_free_idx;
        r_op       <= n_op;
        r_fid      <= n_fid;
        r_off      <= n_off;
        r_sel      <= n_sel;
        r_frame    <= n_frame;
        r_avail    <= n_avail;
        r_sts      <= n_sts;
        r_ridx     <= n_ridx;
        r_rframe   <= n_rframe;
        r_flt      <= n_flt;
        r_o_sts    <= n_o_sts;
        r_o_idx    <= n_o_idx;
        r_o_frame  <= n_o_frame;
        r_o_flt    <= n_o_flt;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_mem[w_ra];
    end

endmodule

/* sv/rcspt_checker.sv */
// Port-level checker of the shared page table and its bind to the top level.
module rcspt_checker import rcspt_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_valid,
    input logic               i_req_ready,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic [STS_W-1:0]   i_rsp_status,
    input logic [IDX_W-1:0]   i_rsp_index,
    input logic [FRAME_W-1:0] i_rsp_frame,
    input logic [FLT_W-1:0]   i_rsp_fault
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while a request is in progress");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_index) && $stable(i_rsp_frame) && $stable(i_rsp_fault)))
        else $error("stalled response changed");

    a_not_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_fault == FLT_NOT_HELD)
            |-> (i_rsp_status == STS_REL_HELD && i_rsp_frame == '0))
        else $error("not-held fault on a response that is no plain release");

    a_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_fault == FLT_AT_MAX) |-> (i_rsp_status == STS_HIT))
        else $error("count-at-maximum fault without a hit");

    a_miss_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status == STS_NOT_FOUND || i_rsp_status == STS_FULL
            || i_rsp_status == STS_NO_FRAME))
            |-> (i_rsp_index == '0 && i_rsp_frame == '0 && i_rsp_fault == FLT_NONE))
        else $error("miss response carries an entry");

endmodule

bind refcounted_shared_page_table rcspt_checker u_rcspt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_status(o_rsp.status),
    .i_rsp_index (o_rsp.result_index),
    .i_rsp_frame (o_rsp.result_frame),
    .i_rsp_fault (o_rsp.fault)
);
